FILE: hdl/fha_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fha_pkg
// Shared sizes, codes and handshake structs for the fit hole allocator.
// ----------------------------------------------------------------------------
package fha_pkg;

   localparam int MAX_HOLES = 32;
   localparam int SIZE_BITS = 16;

   localparam int HOLE_BITS = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
   localparam int CNT_BITS  = $clog2(MAX_HOLES + 1);
   localparam int IN_BITS   = (SIZE_BITS < 16) ? SIZE_BITS : 16;
   localparam int SUM_BITS  = 22;
   // exact free-space sum never wraps; saturation applies at the port only
   localparam int FREE_BITS = (SIZE_BITS + CNT_BITS > SUM_BITS) ?
                              SIZE_BITS + CNT_BITS : SUM_BITS;
   localparam int ADD_BITS  = ((SUM_BITS > SIZE_BITS) ? SUM_BITS : SIZE_BITS) + 1;

   localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

   localparam logic [1:0] CMD_LOAD    = 2'd0;
   localparam logic [1:0] CMD_ALLOC   = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   localparam logic [1:0] MODE_FIRST = 2'd0;
   localparam logic [1:0] MODE_BEST  = 2'd1;
   localparam logic [1:0] MODE_WORST = 2'd2;

   localparam logic [2:0] ST_PLACED  = 3'd0;
   localparam logic [2:0] ST_NOSPACE = 3'd1;
   localparam logic [2:0] ST_STORED  = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_RESTART = 3'd4;

   typedef struct packed {
      logic capture;
      logic scan;
      logic exec;
   } ctl_type;

   typedef struct packed {
      logic scan_done;
   } sts_type;

endpackage
`default_nettype wire

FILE: hdl/fha_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fha_ctrl
// Sequencer: capture, table scan (allocate only), execute, respond.
// ----------------------------------------------------------------------------
module fha_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [1:0]       req_cmd,
   input  wire fha_pkg::sts_type sts,
   output fha_pkg::ctl_type      ctl,
   output logic                  busy,
   output logic                  rsp_strobe
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;
   localparam logic [1:0] S_RESP = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = (req_cmd == fha_pkg::CMD_ALLOC) ? S_SCAN : S_EXEC;
            end
         end
         S_SCAN: begin
            if (sts.scan_done) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC:  state_in = S_RESP;
         S_RESP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign ctl.capture = (state_ff == S_IDLE) && start;
   assign ctl.scan    = (state_ff == S_SCAN);
   assign ctl.exec    = (state_ff == S_EXEC);
   assign busy        = (state_ff != S_IDLE);
   assign rsp_strobe  = (state_ff == S_RESP);

endmodule
`default_nettype wire

FILE: hdl/fha_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fha_datapath
// Hole table, used marks, running sums and the one-entry-per-cycle fit scan.
// ----------------------------------------------------------------------------
module fha_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire fha_pkg::ctl_type ctl,
   output fha_pkg::sts_type      sts,
   input  wire logic [1:0]       req_cmd,
   input  wire logic [15:0]      req_size,
   input  wire logic             csr_write,
   input  wire logic [1:0]       csr_fit_mode,
   output logic [2:0]            rsp_status,
   output logic [4:0]            rsp_hole_index,
   output logic [15:0]           rsp_leftover,
   output logic [21:0]           rsp_internal_total,
   output logic [21:0]           rsp_external_total
);

   logic [fha_pkg::SIZE_BITS-1:0] mem_ff [fha_pkg::MAX_HOLES];
   logic [fha_pkg::MAX_HOLES-1:0] used_ff;
   logic [fha_pkg::CNT_BITS-1:0]  count_ff;
   logic [1:0]                    mode_ff;

   logic [1:0]                    cmd_ff;
   logic [fha_pkg::SIZE_BITS-1:0] size_ff;

   logic [fha_pkg::CNT_BITS-1:0]  addr_ff;
   logic                          pipe_vld_ff;
   logic [fha_pkg::SIZE_BITS-1:0] rd_data_ff;
   logic                          rd_used_ff;
   logic [fha_pkg::HOLE_BITS-1:0] rd_idx_ff;
   logic                          found_ff;
   logic [fha_pkg::HOLE_BITS-1:0] pick_idx_ff;
   logic [fha_pkg::SIZE_BITS-1:0] pick_size_ff;

   logic [fha_pkg::SUM_BITS-1:0]  internal_ff, internal_in;
   logic [fha_pkg::FREE_BITS-1:0] free_ff;
   logic [fha_pkg::FREE_BITS-1:0] loaded_ff;

   logic [2:0]                    status_ff;
   logic [fha_pkg::HOLE_BITS-1:0] index_ff;
   logic [fha_pkg::SIZE_BITS-1:0] left_ff;

   logic                          issue;
   logic                          fits;
   logic                          better;
   logic                          take;
   logic                          full;
   logic [fha_pkg::SIZE_BITS-1:0] left_in;
   logic [fha_pkg::ADD_BITS-1:0]  isum;

   assign issue  = ctl.scan && (addr_ff != count_ff);
   assign fits   = pipe_vld_ff && !rd_used_ff && (rd_data_ff >= size_ff);
   // first fit never replaces its pick, so a full scan gives the same answer
   assign better = !found_ff
                || ((mode_ff == fha_pkg::MODE_BEST)  && (rd_data_ff < pick_size_ff))
                || ((mode_ff == fha_pkg::MODE_WORST) && (rd_data_ff > pick_size_ff));
   assign take   = fits && better;
   assign full   = (count_ff == fha_pkg::CNT_BITS'(fha_pkg::MAX_HOLES));

   assign sts.scan_done = (addr_ff == count_ff) && !pipe_vld_ff;

   assign left_in     = pick_size_ff - size_ff;
   assign isum        = fha_pkg::ADD_BITS'(internal_ff) + fha_pkg::ADD_BITS'(left_in);
   assign internal_in = (isum > fha_pkg::ADD_BITS'(fha_pkg::SUM_MAX)) ?
                        fha_pkg::SUM_MAX : isum[fha_pkg::SUM_BITS-1:0];

   // table storage and scan read port
   always_ff @(posedge clock) begin
      if (ctl.exec && (cmd_ff == fha_pkg::CMD_LOAD) && !full) begin
         mem_ff[count_ff[fha_pkg::HOLE_BITS-1:0]] <= size_ff;
      end
      if (issue) begin
         rd_data_ff <= mem_ff[addr_ff[fha_pkg::HOLE_BITS-1:0]];
         rd_used_ff <= used_ff[addr_ff[fha_pkg::HOLE_BITS-1:0]];
         rd_idx_ff  <= addr_ff[fha_pkg::HOLE_BITS-1:0];
      end
   end

   // request payload, current pick and result fields
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff  <= req_cmd;
         size_ff <= fha_pkg::SIZE_BITS'(req_size[fha_pkg::IN_BITS-1:0]);
      end
      if (take) begin
         pick_idx_ff  <= rd_idx_ff;
         pick_size_ff <= rd_data_ff;
      end
      if (ctl.exec) begin
         case (cmd_ff)
            fha_pkg::CMD_LOAD: begin
               status_ff <= full ? fha_pkg::ST_FULL : fha_pkg::ST_STORED;
               index_ff  <= full ? '0 : count_ff[fha_pkg::HOLE_BITS-1:0];
               left_ff   <= '0;
            end
            fha_pkg::CMD_ALLOC: begin
               status_ff <= found_ff ? fha_pkg::ST_PLACED : fha_pkg::ST_NOSPACE;
               index_ff  <= found_ff ? pick_idx_ff : '0;
               left_ff   <= found_ff ? left_in : '0;
            end
            default: begin
               status_ff <= fha_pkg::ST_RESTART;
               index_ff  <= '0;
               left_ff   <= '0;
            end
         endcase
      end
   end

   // control state: marks, counts, sums, scan pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         count_ff    <= '0;
         mode_ff     <= fha_pkg::MODE_FIRST;
         addr_ff     <= '0;
         pipe_vld_ff <= 1'b0;
         found_ff    <= 1'b0;
         internal_ff <= '0;
         free_ff     <= '0;
         loaded_ff   <= '0;
      end else begin
         if (csr_write) begin
            mode_ff <= csr_fit_mode;
         end
         if (ctl.capture) begin
            addr_ff     <= '0;
            pipe_vld_ff <= 1'b0;
            found_ff    <= 1'b0;
         end else begin
            pipe_vld_ff <= issue;
            if (issue) begin
               addr_ff <= addr_ff + 1'b1;
            end
            if (take) begin
               found_ff <= 1'b1;
            end
         end
         if (ctl.exec) begin
            case (cmd_ff)
               fha_pkg::CMD_LOAD: begin
                  if (!full) begin
                     used_ff[count_ff[fha_pkg::HOLE_BITS-1:0]] <= 1'b0;
                     count_ff  <= count_ff + 1'b1;
                     free_ff   <= free_ff + fha_pkg::FREE_BITS'(size_ff);
                     loaded_ff <= loaded_ff + fha_pkg::FREE_BITS'(size_ff);
                  end
               end
               fha_pkg::CMD_ALLOC: begin
                  if (found_ff) begin
                     used_ff[pick_idx_ff] <= 1'b1;
                     internal_ff          <= internal_in;
                     free_ff              <= free_ff - fha_pkg::FREE_BITS'(pick_size_ff);
                  end
               end
               default: begin
                  used_ff     <= '0;
                  internal_ff <= '0;
                  free_ff     <= loaded_ff;
               end
            endcase
         end
      end
   end

   assign rsp_status         = status_ff;
   assign rsp_hole_index     = 5'(index_ff);
   assign rsp_leftover       = 16'(left_ff);
   assign rsp_internal_total = internal_ff;
   assign rsp_external_total = (free_ff > fha_pkg::FREE_BITS'(fha_pkg::SUM_MAX)) ?
                               fha_pkg::SUM_MAX : free_ff[fha_pkg::SUM_BITS-1:0];

endmodule
`default_nettype wire

FILE: hdl/fit_hole_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fit_hole_allocator
// Fixed-partition hole allocator with first, best and worst fit placement.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the single result has been shown. Load and restart go from capture
// straight to execute and respond. Allocate walks the hole table through its
// one registered read port, one stored hole per cycle, then drains the read
// register and the last compare before execute and respond. rsp_strobe is
// high for exactly one cycle and the receiver cannot hold it off, so it must
// take the result on that cycle; the result fields stay put until the next
// result. fit_mode may be written whenever busy is low (csr_ready).
module fit_hole_allocator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [15:0] req_size,
   output logic             rsp_strobe,
   output logic [2:0]       rsp_status,
   output logic [4:0]       rsp_hole_index,
   output logic [15:0]      rsp_leftover,
   output logic [21:0]      rsp_internal_total,
   output logic [21:0]      rsp_external_total,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_fit_mode
);

   fha_pkg::ctl_type ctl;
   fha_pkg::sts_type sts;
   logic             csr_write;

   assign csr_ready = !busy;
   assign csr_write = csr_valid && csr_ready;

   fha_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_cmd    (req_cmd),
      .sts        (sts),
      .ctl        (ctl),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   fha_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .sts                (sts),
      .req_cmd            (req_cmd),
      .req_size           (req_size),
      .csr_write          (csr_write),
      .csr_fit_mode       (csr_fit_mode),
      .rsp_status         (rsp_status),
      .rsp_hole_index     (rsp_hole_index),
      .rsp_leftover       (rsp_leftover),
      .rsp_internal_total (rsp_internal_total),
      .rsp_external_total (rsp_external_total)
   );

endmodule
`default_nettype wire

FILE: hdl/fha_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fha_checker
// Port-level checks for the fit hole allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fha_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_strobe,
   input wire logic [2:0]  rsp_status,
   input wire logic [4:0]  rsp_hole_index,
   input wire logic [15:0] rsp_leftover,
   input wire logic [21:0] rsp_internal_total
);

   // a result only ever ends a transfer in progress
   a_strobe_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe outside a busy window");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but busy not raised");

   // one result per request: busy drops straight after the strobe
   a_strobe_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy)
      else $error("busy held after result");

   a_nospace_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == fha_pkg::ST_NOSPACE))
         |-> (rsp_hole_index == 5'd0) && (rsp_leftover == 16'd0))
      else $error("no-space result carries index or leftover");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == fha_pkg::ST_RESTART))
         |-> (rsp_internal_total == 22'd0))
      else $error("restart left internal total non-zero");

endmodule

bind fit_hole_allocator fha_checker u_fha_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_strobe         (rsp_strobe),
   .rsp_status         (rsp_status),
   .rsp_hole_index     (rsp_hole_index),
   .rsp_leftover       (rsp_leftover),
   .rsp_internal_total (rsp_internal_total)
);
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for fit_hole_allocator. A short directed table covers
// an empty table, extreme sizes, every fit mode, ties and the restart alias.
// Random phases then fill the hole table and run restart/allocate sequences
// under each mode. Every result is compared field by field with the typed
// result of its plan row or else with an in-bench allocation model.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT = 300000;
   localparam int TARGET_REQUESTS = 650;
   localparam int SETTLE_CYCLES = 40;
   // the 2-bit fields decode their spare code as restart / first fit
   localparam logic [1:0] CMD_RESTART_ALT = 2'd3;
   localparam logic [1:0] MODE_ALT_FIRST = 2'd3;

   typedef struct packed {
      logic [2:0]  status;
      logic [4:0]  hole_index;
      logic [15:0] leftover;
      logic [21:0] internal_total;
      logic [21:0] external_total;
   } outcome_type;

   typedef struct {
      logic [1:0]  mode;
      logic [1:0]  cmd;
      logic [15:0] size;
      bit          typed;
      logic [2:0]  status;
      logic [4:0]  hole_index;
      logic [15:0] leftover;
      logic [21:0] internal_total;
      logic [21:0] external_total;
   } plan_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_cmd;
   logic [15:0] req_size;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [4:0]  rsp_hole_index;
   logic [15:0] rsp_leftover;
   logic [21:0] rsp_internal_total;
   logic [21:0] rsp_external_total;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_fit_mode;

   // allocation model state
   logic [15:0] hole_len [fha_pkg::MAX_HOLES];
   bit          hole_taken [fha_pkg::MAX_HOLES];
   int          holes_loaded;
   logic [21:0] frag_internal;
   logic [21:0] frag_free;
   logic [1:0]  mode_now;

   outcome_type  due_outcomes[$];
   plan_row_type plan[$];
   int           mismatch_count;
   int           requests_sent;
   int           cycle_count;
   int           next_gap;
   int           idle_max;

   fit_hole_allocator u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_size           (req_size),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_hole_index     (rsp_hole_index),
      .rsp_leftover       (rsp_leftover),
      .rsp_internal_total (rsp_internal_total),
      .rsp_external_total (rsp_external_total),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_fit_mode       (csr_fit_mode)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [21:0] free_space();
      longint acc;
      acc = 0;
      for (int i = 0; i < holes_loaded; i++)
         if (!hole_taken[i]) acc += hole_len[i];
      return (acc > fha_pkg::SUM_MAX) ? fha_pkg::SUM_MAX : acc[21:0];
   endfunction

   function automatic outcome_type predict_outcome(input logic [1:0] cmd,
                                                   input logic [15:0] size);
      outcome_type r;
      int          pick;
      bit          found;
      longint      acc;
      r = '0;
      pick = 0;
      found = 0;
      case (cmd)
         fha_pkg::CMD_LOAD: begin
            if (holes_loaded < fha_pkg::MAX_HOLES) begin
               r.hole_index = 5'(holes_loaded);
               hole_len[holes_loaded] = size;
               hole_taken[holes_loaded] = 0;
               holes_loaded++;
               frag_free = free_space();
               r.status = fha_pkg::ST_STORED;
            end else begin
               r.status = fha_pkg::ST_FULL;
            end
         end
         fha_pkg::CMD_ALLOC: begin
            for (int i = 0; i < holes_loaded; i++) begin
               if (hole_taken[i] || hole_len[i] < size) continue;
               if (!found) begin
                  found = 1;
                  pick = i;
                  if (mode_now != fha_pkg::MODE_BEST && mode_now != fha_pkg::MODE_WORST)
                     break;
               end else if (mode_now == fha_pkg::MODE_BEST &&
                            hole_len[i] < hole_len[pick]) begin
                  pick = i;
               end else if (mode_now == fha_pkg::MODE_WORST &&
                            hole_len[i] > hole_len[pick]) begin
                  pick = i;
               end
            end
            if (found) begin
               hole_taken[pick] = 1;
               r.hole_index = 5'(pick);
               r.leftover = hole_len[pick] - size;
               acc = longint'(frag_internal) + r.leftover;
               frag_internal = (acc > fha_pkg::SUM_MAX) ? fha_pkg::SUM_MAX : acc[21:0];
               frag_free = free_space();
               r.status = fha_pkg::ST_PLACED;
            end else begin
               r.status = fha_pkg::ST_NOSPACE;
            end
         end
         default: begin
            for (int i = 0; i < fha_pkg::MAX_HOLES; i++) hole_taken[i] = 0;
            frag_internal = '0;
            frag_free = free_space();
            r.status = fha_pkg::ST_RESTART;
         end
      endcase
      r.internal_total = frag_internal;
      r.external_total = frag_free;
      return r;
   endfunction

   // Entered at a clock edge; leaves start high only when the next request
   // follows with no gap.
   task automatic send_request(input logic [1:0] cmd, input logic [15:0] size,
                               input bit typed, input outcome_type typed_want);
      outcome_type want;
      if (next_gap != 0) repeat (next_gap) @(posedge clock);
      start <= 1'b1;
      req_cmd <= cmd;
      req_size <= size;
      do @(posedge clock); while (busy);
      want = predict_outcome(cmd, size);
      if (typed) want = typed_want;
      due_outcomes.push_back(want);
      requests_sent++;
      next_gap = $urandom_range(0, idle_max);
      if (next_gap != 0) start <= 1'b0;
   endtask

   task automatic drain();
      if (next_gap == 0) begin
         start <= 1'b0;
         next_gap = 1;
      end
      while (due_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic write_mode(input logic [1:0] mode);
      csr_valid <= 1'b1;
      csr_fit_mode <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mode_now = mode;
   endtask

   function automatic logic [15:0] random_hole();
      case ($urandom_range(0, 7))
         0: return 16'd0;
         1: return 16'hFFFF;
         2, 3: begin
            case ($urandom_range(0, 3))
               0: return 16'd64;
               1: return 16'd512;
               2: return 16'd4096;
               default: return 16'd20000;
            endcase
         end
         4: return 16'($urandom_range(0, 1000));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] random_process();
      logic [15:0] base;
      int          slack;
      base = hole_len[$urandom_range(0, holes_loaded - 1)];
      slack = (base < 500) ? base : 500;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return base;
         4, 5: return base - 16'($urandom_range(0, slack));
         6: return base + 16'd1;
         7: return 16'($urandom);
         8: return 16'd0;
         default: return 16'hFFFF;
      endcase
   endfunction

   always @(posedge clock) begin : check_outcome
      outcome_type want;
      if (!reset && rsp_strobe) begin
         if (due_outcomes.size() == 0) begin
            $error("result transfer with nothing outstanding");
            mismatch_count++;
         end else begin
            want = due_outcomes.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_hole_index !== want.hole_index) begin
               $error("hole_index: expected %0d, got %0d", want.hole_index,
                      rsp_hole_index);
               mismatch_count++;
            end
            if (rsp_leftover !== want.leftover) begin
               $error("leftover: expected %0d, got %0d", want.leftover, rsp_leftover);
               mismatch_count++;
            end
            if (rsp_internal_total !== want.internal_total) begin
               $error("internal_total: expected %0d, got %0d", want.internal_total,
                      rsp_internal_total);
               mismatch_count++;
            end
            if (rsp_external_total !== want.external_total) begin
               $error("external_total: expected %0d, got %0d", want.external_total,
                      rsp_external_total);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      outcome_type want;
      logic [1:0]  cmd;
      int          phase;
      int          span;
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_cmd = fha_pkg::CMD_LOAD;
      req_size = '0;
      csr_valid = 1'b0;
      csr_fit_mode = fha_pkg::MODE_FIRST;
      for (int i = 0; i < fha_pkg::MAX_HOLES; i++) begin
         hole_len[i] = '0;
         hole_taken[i] = 0;
      end
      holes_loaded = 0;
      frag_internal = '0;
      frag_free = '0;
      mode_now = fha_pkg::MODE_FIRST;
      mismatch_count = 0;
      requests_sent = 0;
      cycle_count = 0;
      next_gap = 0;
      idle_max = 4;

      // mode, cmd, size, typed, then the expected result where typed
      plan.push_back('{fha_pkg::MODE_FIRST, fha_pkg::CMD_ALLOC, 16'd5, 1,
                       fha_pkg::ST_NOSPACE, 0, 0, 0, 0});
      plan.push_back('{fha_pkg::MODE_FIRST, fha_pkg::CMD_RESTART, 16'd0, 1,
                       fha_pkg::ST_RESTART, 0, 0, 0, 0});
      plan.push_back('{fha_pkg::MODE_FIRST, fha_pkg::CMD_LOAD, 16'd0, 1,
                       fha_pkg::ST_STORED, 0, 0, 0, 0});
      plan.push_back('{fha_pkg::MODE_FIRST, fha_pkg::CMD_LOAD, 16'hFFFF, 1,
                       fha_pkg::ST_STORED, 1, 0, 0, 65535});
      plan.push_back('{fha_pkg::MODE_FIRST, fha_pkg::CMD_LOAD, 16'd100, 1,
                       fha_pkg::ST_STORED, 2, 0, 0, 65635});
      plan.push_back('{fha_pkg::MODE_FIRST, fha_pkg::CMD_ALLOC, 16'd0, 1,
                       fha_pkg::ST_PLACED, 0, 0, 0, 65635});
      plan.push_back('{fha_pkg::MODE_FIRST, fha_pkg::CMD_ALLOC, 16'hFFFF, 1,
                       fha_pkg::ST_PLACED, 1, 0, 0, 100});
      plan.push_back('{fha_pkg::MODE_FIRST, fha_pkg::CMD_ALLOC, 16'd101, 1,
                       fha_pkg::ST_NOSPACE, 0, 0, 0, 100});
      plan.push_back('{fha_pkg::MODE_FIRST, CMD_RESTART_ALT, 16'hFFFF, 1,
                       fha_pkg::ST_RESTART, 0, 0, 0, 65635});
      plan.push_back('{fha_pkg::MODE_BEST, fha_pkg::CMD_LOAD, 16'd50, 0, 0, 0, 0, 0, 0});
      plan.push_back('{fha_pkg::MODE_BEST, fha_pkg::CMD_LOAD, 16'd100, 0, 0, 0, 0, 0, 0});
      plan.push_back('{fha_pkg::MODE_BEST, fha_pkg::CMD_ALLOC, 16'd60, 0, 0, 0, 0, 0, 0});
      plan.push_back('{fha_pkg::MODE_BEST, fha_pkg::CMD_ALLOC, 16'd60, 0, 0, 0, 0, 0, 0});
      plan.push_back('{fha_pkg::MODE_BEST, fha_pkg::CMD_ALLOC, 16'd1, 0, 0, 0, 0, 0, 0});
      plan.push_back('{fha_pkg::MODE_WORST, fha_pkg::CMD_RESTART, 16'd0, 0,
                       0, 0, 0, 0, 0});
      plan.push_back('{fha_pkg::MODE_WORST, fha_pkg::CMD_ALLOC, 16'd1, 0, 0, 0, 0, 0, 0});
      plan.push_back('{fha_pkg::MODE_WORST, fha_pkg::CMD_ALLOC, 16'd1, 0, 0, 0, 0, 0, 0});
      plan.push_back('{fha_pkg::MODE_WORST, fha_pkg::CMD_ALLOC, 16'hFFFF, 0,
                       0, 0, 0, 0, 0});
      plan.push_back('{MODE_ALT_FIRST, fha_pkg::CMD_ALLOC, 16'd0, 0, 0, 0, 0, 0, 0});
      plan.push_back('{MODE_ALT_FIRST, fha_pkg::CMD_ALLOC, 16'd100, 0, 0, 0, 0, 0, 0});
      plan.push_back('{fha_pkg::MODE_FIRST, fha_pkg::CMD_RESTART, 16'd0, 0,
                       0, 0, 0, 0, 0});
      plan.push_back('{fha_pkg::MODE_FIRST, fha_pkg::CMD_ALLOC, 16'd50, 0, 0, 0, 0, 0, 0});

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[k]) begin
         if (plan[k].mode != mode_now) begin
            drain();
            write_mode(plan[k].mode);
         end
         want = '{plan[k].status, plan[k].hole_index, plan[k].leftover,
                  plan[k].internal_total, plan[k].external_total};
         send_request(plan[k].cmd, plan[k].size, plan[k].typed, want);
      end

      // fill the table, then overflow it; it stays full for the rest of the run
      while (holes_loaded < fha_pkg::MAX_HOLES)
         send_request(fha_pkg::CMD_LOAD, random_hole(), 0, '0);
      repeat (2) send_request(fha_pkg::CMD_LOAD, random_hole(), 0, '0);

      phase = 0;
      while (requests_sent < TARGET_REQUESTS) begin
         drain();
         write_mode((phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3)));
         idle_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
         send_request($urandom_range(0, 1) ? fha_pkg::CMD_RESTART : CMD_RESTART_ALT,
                      16'($urandom), 0, '0);
         span = $urandom_range(15, 40);
         repeat (span) begin
            case ($urandom_range(0, 19))
               0, 1: cmd = fha_pkg::CMD_RESTART;
               2: cmd = CMD_RESTART_ALT;
               3, 4: cmd = fha_pkg::CMD_LOAD;
               default: cmd = fha_pkg::CMD_ALLOC;
            endcase
            send_request(cmd,
                         (cmd == fha_pkg::CMD_ALLOC) ? random_process() : 16'($urandom),
                         0, '0);
         end
         phase++;
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && due_outcomes.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
